[rtl/core/wts_pkg.sv]
// wts_pkg: shared constants for the windowed trend statistics block
// no dependencies
`timescale 1ns / 1ps

package wts_pkg;

   localparam int WINDOW_DEPTH_DEF = 64;
   localparam int SAMPLE_BITS_DEF  = 20;

   localparam int PERIOD_BITS = 6;
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(7);

   localparam int OUT_BITS   = 20;
   localparam int PCT_BITS   = 28;
   localparam int COUNT_BITS = 32;
   localparam int PCT_SCALE  = 100;

   localparam logic [OUT_BITS-1:0]   OUT_MAX   = {OUT_BITS{1'b1}};
   localparam logic [PCT_BITS-1:0]   PCT_MAX   = {1'b0, {(PCT_BITS-1){1'b1}}};
   localparam logic [PCT_BITS:0]     PCT_LIM   = {2'b01, {(PCT_BITS-1){1'b0}}};
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

endpackage

[rtl/core/wts_req_if.sv]
// wts_req_if: request channel carrying one signed sample
// depends on wts_pkg
`timescale 1ns / 1ps

interface wts_req_if #(
   parameter int SAMPLE_BITS = wts_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

[rtl/core/wts_rsp_if.sv]
// wts_rsp_if: response channel carrying the window statistics
// depends on wts_pkg
`timescale 1ns / 1ps

interface wts_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [wts_pkg::OUT_BITS-1:0]           avg_increase;
   logic                                   increase_valid;
   logic signed [wts_pkg::PCT_BITS-1:0]    relative_change_pct;
   logic                                   change_valid;
   logic [wts_pkg::OUT_BITS-1:0]           std_dev;
   logic                                   std_valid;
   logic                                   switch_occurred;
   logic [wts_pkg::COUNT_BITS-1:0]         switch_total;

   modport source (output valid, output avg_increase, output increase_valid,
                   output relative_change_pct, output change_valid, output std_dev,
                   output std_valid, output switch_occurred, output switch_total,
                   input ready);
   modport sink   (input valid, input avg_increase, input increase_valid,
                   input relative_change_pct, input change_valid, input std_dev,
                   input std_valid, input switch_occurred, input switch_total,
                   output ready);
endinterface

[rtl/core/wts_ram.sv]
// wts_ram: generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module wts_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/core/wts_div.sv]
// wts_div: restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps

module wts_div #(
   parameter int DW = 30,
   parameter int VW = 22
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          busy,
   output logic [DW-1:0] quotient
);
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff;
   logic [VW-1:0] rem_ff;
   logic [VW-1:0] dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic [VW:0]   rem_sh;
   logic          ge;
   logic [VW:0]   rem_sub;

   assign rem_sh  = {rem_ff, quo_ff[DW-1]};
   assign ge      = rem_sh >= {1'b0, dvs_ff};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(DW);
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DW-2:0], ge};
         rem_ff <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

[rtl/core/wts_sqrt.sv]
// wts_sqrt: digit by digit integer square root, two radicand bits per cycle
// no dependencies
`timescale 1ns / 1ps

module wts_sqrt #(
   parameter int RW = 54
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RW-1:0]     radicand,
   output logic              busy,
   output logic [RW/2-1:0]   root
);
   localparam int HW = RW / 2;
   localparam int CW = $clog2(HW + 1);

   logic [RW-1:0] rad_ff;
   logic [HW-1:0] root_ff;
   logic [HW:0]   rem_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic [HW+2:0] rem_sh;
   logic [HW+2:0] trial;
   logic          ge;
   logic [HW+2:0] rem_sub;

   assign rem_sh  = {rem_ff, rad_ff[RW-1:RW-2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign ge      = rem_sh >= trial;
   assign rem_sub = rem_sh - trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(HW);
         rad_ff  <= radicand;
         root_ff <= '0;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RW-3:0], 2'b00};
         root_ff <= {root_ff[HW-2:0], ge};
         rem_ff  <= ge ? rem_sub[HW:0] : rem_sh[HW:0];
         cnt_ff  <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;
endmodule

[rtl/core/windowed_trend_statistics.sv]
// windowed_trend_statistics: moving window deviation and trend over a sample stream
// depends on wts_pkg, wts_req_if, wts_rsp_if, wts_ram, wts_div, wts_sqrt
`timescale 1ns / 1ps

// Each nonzero request is written into the window ram and answered with one
// response holding the mean positive increase, the rounded percent change
// against the sample period steps back, the population standard deviation of
// the last period samples and a tendency switch flag with a saturating total.
// A zero sample is dropped and gives no response. Each request runs a sweep
// back through the window over the single ram read port, then three passes of
// the shared one-bit-per-cycle divider, with the square root running beside
// the first. Requests are taken one at a time; a finished response waits in
// its output register while the next request is accepted. The period register
// must be written only while the block is idle.
module windowed_trend_statistics #(
   parameter int WINDOW_DEPTH = wts_pkg::WINDOW_DEPTH_DEF,
   parameter int SAMPLE_BITS  = wts_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   wts_req_if.sink                           req_ch,
   wts_rsp_if.source                         rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [wts_pkg::PERIOD_BITS-1:0]   csr_wr_data
);
   localparam int PB    = wts_pkg::PERIOD_BITS;
   localparam int OB    = wts_pkg::OUT_BITS;
   localparam int PCB   = wts_pkg::PCT_BITS;
   localparam int CB    = wts_pkg::COUNT_BITS;
   localparam int AW    = $clog2(WINDOW_DEPTH);
   localparam int SW    = $clog2(WINDOW_DEPTH + 1);
   localparam int CMPW  = (SW > PB) ? SW : PB;
   localparam int SUMW  = SAMPLE_BITS + PB;
   localparam int SQPW  = 2 * SAMPLE_BITS;
   localparam int SQW   = 2 * SAMPLE_BITS + PB;
   localparam int RISEW = SAMPLE_BITS + PB + 1;
   localparam int VARW  = 2 * SUMW;
   localparam int RADW  = VARW + 2;
   localparam int ROOTW = RADW / 2;
   localparam int NUMW  = SAMPLE_BITS + 9;
   localparam int MAGW  = SAMPLE_BITS + 1;
   localparam int DW    = NUMW + 1;
   localparam int VW    = MAGW + 1;
   localparam int EXW   = DW + OB + PCB;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SWEEP = 4'd1;
   localparam logic [3:0] ST_MUL   = 4'd2;
   localparam logic [3:0] ST_VAR   = 4'd3;
   localparam logic [3:0] ST_AVG   = 4'd4;
   localparam logic [3:0] ST_PCT   = 4'd5;
   localparam logic [3:0] ST_SQ    = 4'd6;
   localparam logic [3:0] ST_SD    = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   logic [3:0]                    state_ff;
   logic [PB-1:0]                 period_ff;
   logic [PB-1:0]                 n;
   logic [AW-1:0]                 wi_ff;
   logic [AW-1:0]                 wi_prev;
   logic [SW-1:0]                 seen_ff;
   logic [SW-1:0]                 seen_in;
   logic                          inc_in;
   logic                          std_in;
   logic                          inc_ff;
   logic                          std_ff;
   logic                          acc;
   logic                          nonzero;

   logic signed [SAMPLE_BITS-1:0] new_ff;
   logic signed [SAMPLE_BITS-1:0] prev_ff;
   logic signed [SAMPLE_BITS-1:0] old_ff;
   logic signed [SAMPLE_BITS-1:0] cur;
   logic signed [SUMW-1:0]        sum_ff;
   logic [SQPW-1:0]               sqm_ff;
   logic                          sqv_ff;
   logic [SQW-1:0]                sqacc_ff;
   logic [RISEW-1:0]              rise_ff;
   logic signed [MAGW-1:0]        dif;
   logic signed [SQPW-1:0]        samp_x;
   logic signed [SQPW-1:0]        cur_x;

   logic [AW-1:0]                 addr_ff;
   logic [PB:0]                   k_ff;
   logic [PB-1:0]                 last_ff;
   logic                          issue;
   logic                          p1_valid_ff;
   logic                          p1_win_ff;
   logic                          p1_old_ff;

   logic [VARW-1:0]               a_ff;
   logic [VARW-1:0]               b_ff;
   logic signed [VARW-1:0]        sum_x;
   logic signed [VARW-1:0]        sum_sq;
   logic signed [NUMW-1:0]        num_ff;
   logic signed [NUMW-1:0]        diff_x;
   logic [VARW-1:0]               var_w;
   logic [NUMW-1:0]               an;
   logic [MAGW-1:0]               ad;
   logic signed [MAGW-1:0]        old_x;

   logic                          div_start;
   logic [DW-1:0]                 div_dvd;
   logic [VW-1:0]                 div_dvs;
   logic                          div_busy;
   logic [DW-1:0]                 div_q;
   logic [EXW-1:0]                q_ext;
   logic [EXW-1:0]                k_ext;
   logic                          sq_start;
   logic                          sq_busy;
   logic [ROOTW-1:0]              root;

   logic [OB-1:0]                 avg_ff;
   logic signed [PCB-1:0]         pct_ff;
   logic signed [PCB-1:0]         pct_in;
   logic [PCB:0]                  qs;
   logic [OB-1:0]                 sd_ff;
   logic signed [PCB-1:0]         last_chg_ff;
   logic [CB-1:0]                 swcnt_ff;
   logic                          sw;

   logic                          rsp_valid_ff;
   logic [OB-1:0]                 rsp_avg_ff;
   logic                          rsp_inc_ff;
   logic signed [PCB-1:0]         rsp_pct_ff;
   logic [OB-1:0]                 rsp_sd_ff;
   logic                          rsp_std_ff;
   logic                          rsp_sw_ff;
   logic [CB-1:0]                 rsp_cnt_ff;

   // control decode
   assign n       = (period_ff == '0) ? PB'(1) : period_ff;
   assign acc     = req_ch.valid && req_ch.ready;
   assign nonzero = req_ch.sample != '0;
   assign req_ch.ready = state_ff == ST_IDLE;
   assign wi_prev = (wi_ff == '0) ? AW'(WINDOW_DEPTH - 1) : wi_ff - AW'(1);
   assign seen_in = (seen_ff == SW'(WINDOW_DEPTH)) ? seen_ff : seen_ff + SW'(1);
   assign inc_in  = CMPW'(seen_in) > CMPW'(n);
   assign std_in  = CMPW'(seen_in) >= CMPW'(n);
   assign issue   = (state_ff == ST_SWEEP) && (k_ff <= {1'b0, last_ff});

   wts_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (acc && nonzero),
      .wr_addr (wi_ff),
      .wr_data (req_ch.sample),
      .rd_en   (issue),
      .rd_addr (addr_ff),
      .rd_data (cur)
   );

   // sweep datapath
   assign dif    = MAGW'(prev_ff) - MAGW'(cur);
   assign samp_x = SQPW'(req_ch.sample);
   assign cur_x  = SQPW'(cur);
   assign sum_x  = VARW'(sum_ff);
   assign sum_sq = sum_x * sum_x;
   assign diff_x = NUMW'(new_ff) - NUMW'(old_ff);
   assign var_w  = (a_ff > b_ff) ? a_ff - b_ff : '0;
   assign old_x  = MAGW'(old_ff);
   assign ad     = old_x[MAGW-1] ? MAGW'(-old_x) : MAGW'(old_x);
   assign an     = num_ff[NUMW-1] ? NUMW'(-num_ff) : NUMW'(num_ff);

   // shared divider and square root
   assign sq_start = state_ff == ST_VAR;
   always_comb begin
      div_start = 1'b0;
      div_dvd   = '0;
      div_dvs   = '0;
      unique case (state_ff)
         ST_VAR: begin
            div_start = 1'b1;
            div_dvd   = DW'({rise_ff, 1'b0}) + DW'(n);
            div_dvs   = VW'({n, 1'b0});
         end
         ST_AVG: begin
            div_start = !div_busy;
            div_dvd   = DW'({an, 1'b0}) + DW'(ad);
            div_dvs   = VW'({ad, 1'b0});
         end
         ST_SQ: begin
            div_start = !sq_busy;
            div_dvd   = DW'(root);
            div_dvs   = VW'(n);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   wts_div #(
      .DW (DW),
      .VW (VW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .quotient (div_q)
   );

   wts_sqrt #(
      .RW (RADW)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand ({var_w, 2'b00}),
      .busy     (sq_busy),
      .root     (root)
   );

   // result shaping
   assign q_ext = EXW'(div_q);
   assign k_ext = (q_ext + EXW'(1)) >> 1;
   assign qs    = (q_ext > EXW'(wts_pkg::PCT_LIM)) ? wts_pkg::PCT_LIM : q_ext[PCB:0];
   always_comb begin
      if (ad == '0) begin
         pct_in = '0;
      end else if (num_ff[NUMW-1] != old_ff[SAMPLE_BITS-1]) begin
         pct_in = PCB'(-qs);
      end else if (qs > {1'b0, wts_pkg::PCT_MAX}) begin
         pct_in = wts_pkg::PCT_MAX;
      end else begin
         pct_in = qs[PCB-1:0];
      end
   end
   assign sw = inc_ff && (last_chg_ff != '0) && (last_chg_ff[PCB-1] != pct_ff[PCB-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= wts_pkg::PERIOD_RESET;
         wi_ff        <= '0;
         seen_ff      <= '0;
         p1_valid_ff  <= 1'b0;
         sqv_ff       <= 1'b0;
         last_chg_ff  <= '0;
         swcnt_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_ch.ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         // read pipeline
         p1_valid_ff <= issue;
         if (issue) begin
            addr_ff   <= (addr_ff == '0) ? AW'(WINDOW_DEPTH - 1) : addr_ff - AW'(1);
            k_ff      <= k_ff + (PB + 1)'(1);
            p1_win_ff <= k_ff < {1'b0, n};
            p1_old_ff <= k_ff == {1'b0, n};
         end
         sqv_ff <= (p1_valid_ff && p1_win_ff) || (acc && nonzero);
         if (sqv_ff) begin
            sqacc_ff <= sqacc_ff + SQW'(sqm_ff);
         end
         if (p1_valid_ff) begin
            prev_ff <= cur;
            if (!dif[MAGW-1] && dif != '0) begin
               rise_ff <= rise_ff + RISEW'(dif);
            end
            if (p1_win_ff) begin
               sum_ff <= sum_ff + SUMW'(cur);
               sqm_ff <= SQPW'(cur_x * cur_x);
            end
            if (p1_old_ff) begin
               old_ff <= cur;
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (acc && nonzero) begin
                  state_ff <= ST_SWEEP;
                  wi_ff    <= (wi_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : wi_ff + AW'(1);
                  seen_ff  <= seen_in;
                  inc_ff   <= inc_in;
                  std_ff   <= std_in;
                  new_ff   <= req_ch.sample;
                  prev_ff  <= req_ch.sample;
                  old_ff   <= req_ch.sample;
                  sum_ff   <= SUMW'(req_ch.sample);
                  sqm_ff   <= SQPW'(samp_x * samp_x);
                  sqacc_ff <= '0;
                  rise_ff  <= '0;
                  addr_ff  <= wi_prev;
                  k_ff     <= (PB + 1)'(1);
                  last_ff  <= inc_in ? n : (std_in ? n - PB'(1) : '0);
               end
            end
            ST_SWEEP: begin
               if (!issue && !p1_valid_ff && !sqv_ff) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               a_ff     <= VARW'(n) * VARW'(sqacc_ff);
               b_ff     <= VARW'(sum_sq);
               num_ff   <= diff_x * $signed(NUMW'(wts_pkg::PCT_SCALE));
               state_ff <= ST_VAR;
            end
            ST_VAR: begin
               state_ff <= ST_AVG;
            end
            ST_AVG: begin
               if (!div_busy) begin
                  avg_ff   <= (q_ext > EXW'(wts_pkg::OUT_MAX)) ? wts_pkg::OUT_MAX
                                                                : q_ext[OB-1:0];
                  state_ff <= ST_PCT;
               end
            end
            ST_PCT: begin
               if (!div_busy) begin
                  pct_ff   <= pct_in;
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               if (!sq_busy) begin
                  state_ff <= ST_SD;
               end
            end
            ST_SD: begin
               if (!div_busy) begin
                  sd_ff    <= (k_ext > EXW'(wts_pkg::OUT_MAX)) ? wts_pkg::OUT_MAX
                                                                : k_ext[OB-1:0];
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_avg_ff   <= inc_ff ? avg_ff : '0;
                  rsp_inc_ff   <= inc_ff;
                  rsp_pct_ff   <= inc_ff ? pct_ff : last_chg_ff;
                  rsp_sd_ff    <= std_ff ? sd_ff : '0;
                  rsp_std_ff   <= std_ff;
                  rsp_sw_ff    <= sw;
                  if (sw && swcnt_ff != wts_pkg::COUNT_MAX) begin
                     swcnt_ff   <= swcnt_ff + CB'(1);
                     rsp_cnt_ff <= swcnt_ff + CB'(1);
                  end else begin
                     rsp_cnt_ff <= swcnt_ff;
                  end
                  if (inc_ff) begin
                     last_chg_ff <= pct_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.avg_increase        = rsp_avg_ff;
   assign rsp_ch.increase_valid      = rsp_inc_ff;
   assign rsp_ch.relative_change_pct = rsp_pct_ff;
   assign rsp_ch.change_valid        = rsp_inc_ff;
   assign rsp_ch.std_dev             = rsp_sd_ff;
   assign rsp_ch.std_valid           = rsp_std_ff;
   assign rsp_ch.switch_occurred     = rsp_sw_ff;
   assign rsp_ch.switch_total        = rsp_cnt_ff;

`ifndef SYNTHESIS
   a_accept_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (acc && nonzero) |=> (state_ff == ST_SWEEP))
      else $error("nonzero request did not start the window sweep");

   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SW'(WINDOW_DEPTH))
      else $error("sample count beyond window depth");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (swcnt_ff >= $past(swcnt_ff)))
      else $error("switch total decreased");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done step");
`endif
endmodule

[bench/windowed_trend_statistics_test.sv]
// windowed_trend_statistics_test: self-checking bench for the trend statistics block
// depends on wts_pkg, wts_req_if, wts_rsp_if and windowed_trend_statistics
// directed table at reset period, then random sample phases over several periods
`timescale 1ns / 1ps

module windowed_trend_statistics_test;
   localparam int DEPTH       = wts_pkg::WINDOW_DEPTH_DEF;
   localparam int SBITS       = wts_pkg::SAMPLE_BITS_DEF;
   localparam int DRAIN       = 400;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [wts_pkg::OUT_BITS-1:0]   avg_increase;
      logic                           increase_valid;
      logic [wts_pkg::PCT_BITS-1:0]   relative_change_pct;
      logic                           change_valid;
      logic [wts_pkg::OUT_BITS-1:0]   std_dev;
      logic                           std_valid;
      logic                           switch_occurred;
      logic [wts_pkg::COUNT_BITS-1:0] switch_total;
   } stats_type;

   typedef struct {
      logic signed [SBITS-1:0] sample;
      bit                      known;
      stats_type               stats;
   } step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [wts_pkg::PERIOD_BITS-1:0] csr_wr_data = '0;

   wts_req_if req_ch ();
   wts_rsp_if rsp_ch ();

   windowed_trend_statistics dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // predictor state
   longint           win[DEPTH];
   int               wr_pos;
   int               seen;
   longint           prev_change;
   bit [31:0]        switch_cnt;
   int               period_reg;

   stats_type        pending_stats[$];
   int               errors = 0;
   int               cycles = 0;
   int               req_idle_pct = 27;
   int               rsp_idle_pct = 48;
   logic signed [SBITS-1:0] last_sample = 1;

   function automatic longint win_back(int k);
      return win[(wr_pos + DEPTH - 1 - (k % DEPTH)) % DEPTH];
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unsigned rounded_root(longint unsigned v, longint unsigned n);
      longint unsigned lo, hi, mid, t;
      lo = 0;
      hi = wts_pkg::OUT_MAX;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         t = (2 * mid - 1) * n;
         if (t * t <= 4 * v) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic stats_type window_stats(logic signed [SBITS-1:0] s);
      stats_type r;
      longint n, oldv, newv, num, chg, d, x, wsum;
      longint unsigned rise, an, ad, q, sq, a, b, v;
      bit inc_ok, std_ok, sw;
      r = '0;
      sw = 0;
      win[wr_pos] = s;
      wr_pos = (wr_pos + 1) % DEPTH;
      if (seen < DEPTH) seen++;
      n = period_reg == 0 ? 1 : period_reg;
      inc_ok = seen > n;
      std_ok = seen >= n;
      if (inc_ok) begin
         rise = 0;
         for (int k = 0; k < n; k++) begin
            d = win_back(k) - win_back(k + 1);
            if (d > 0) rise += d;
         end
         q = (2 * rise + n) / (2 * n);
         r.avg_increase = q > wts_pkg::OUT_MAX ? wts_pkg::OUT_MAX
                                               : q[wts_pkg::OUT_BITS-1:0];
         oldv = win_back(n);
         newv = win_back(0);
         num = (newv - oldv) * wts_pkg::PCT_SCALE;
         an = magnitude(num);
         ad = magnitude(oldv);
         chg = 0;
         if (ad != 0) begin
            q = (2 * an + ad) / (2 * ad);
            if (q > 134217728) q = 134217728;
            if ((num < 0) != (oldv < 0)) chg = -longint'(q);
            else chg = q > 134217727 ? 134217727 : longint'(q);
         end
         if (prev_change != 0 && ((prev_change < 0) != (chg < 0))) begin
            sw = 1;
            if (switch_cnt != wts_pkg::COUNT_MAX) switch_cnt++;
         end
         prev_change = chg;
      end
      if (std_ok) begin
         wsum = 0;
         sq = 0;
         for (int k = 0; k < n; k++) begin
            x = win_back(k);
            wsum += x;
            sq += magnitude(x) * magnitude(x);
         end
         a = n * sq;
         b = magnitude(wsum) * magnitude(wsum);
         v = a > b ? a - b : 0;
         r.std_dev = wts_pkg::OUT_BITS'(rounded_root(v, n));
      end
      r.increase_valid = inc_ok;
      r.change_valid = inc_ok;
      r.relative_change_pct = prev_change[wts_pkg::PCT_BITS-1:0];
      r.std_valid = std_ok;
      r.switch_occurred = sw;
      r.switch_total = switch_cnt;
      return r;
   endfunction

   task automatic send_sample(logic signed [SBITS-1:0] s, bit known, stats_type typed);
      stats_type calc;
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.sample <= s;
      do @(posedge clock); while (!req_ch.ready);
      if (s != 0) begin
         calc = window_stats(s);
         pending_stats.insert(pending_stats.size(), known ? typed : calc);
      end
   endtask

   task automatic write_period(int p);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait (pending_stats.size() == 0);
      repeat (DRAIN) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= p[wts_pkg::PERIOD_BITS-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      period_reg = p;
   endtask

   function automatic logic signed [SBITS-1:0] random_sample();
      int pick;
      logic signed [SBITS-1:0] s;
      pick = $urandom_range(99);
      if (pick < 5) s = '0;
      else if (pick < 30) s = SBITS'($urandom_range(2000)) - SBITS'(1000);
      else if (pick < 40) begin
         case ($urandom_range(3))
            0: s = 20'sh7ffff;
            1: s = 20'sh80000;
            2: s = SBITS'(1);
            default: s = {SBITS{1'b1}};
         endcase
      end else if (pick < 65) s = last_sample + SBITS'($urandom_range(512)) - SBITS'(256);
      else s = SBITS'($urandom());
      last_sample = s;
      return s;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
      end
   endtask

   always @(negedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      stats_type e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("windowed_trend_statistics regression: fail");
         $finish;
      end else if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_stats.size() == 0) begin
            errors++;
            $display("%0t unexpected response: expected none actual %0h", $time,
                     rsp_ch.std_dev);
         end else begin
            e = pending_stats.pop_front();
            check_field("avg_increase", 32'(e.avg_increase), 32'(rsp_ch.avg_increase));
            check_field("increase_valid", 32'(e.increase_valid),
                        32'(rsp_ch.increase_valid));
            check_field("relative_change_pct", 32'(e.relative_change_pct),
                        32'($unsigned(rsp_ch.relative_change_pct)));
            check_field("change_valid", 32'(e.change_valid), 32'(rsp_ch.change_valid));
            check_field("std_dev", 32'(e.std_dev), 32'(rsp_ch.std_dev));
            check_field("std_valid", 32'(e.std_valid), 32'(rsp_ch.std_valid));
            check_field("switch_occurred", 32'(e.switch_occurred),
                        32'(rsp_ch.switch_occurred));
            check_field("switch_total", 32'(e.switch_total), 32'(rsp_ch.switch_total));
         end
      end
   end

   initial begin
      step_type                plan[24];
      logic signed [SBITS-1:0] dir_samples[23];
      int                      periods[7];
      int                      counts[7];
      int                      sent;
      periods = '{1, 0, 63, 2, 30, 5, 7};
      counts  = '{60, 50, 130, 60, 90, 60, 50};
      dir_samples = '{20'sd0, 20'sh80000, 20'sd1, -20'sd1, 20'sd256, 20'sd0,
                      20'sh7ffff, 20'sh80000, 20'sd100, 20'sd200, -20'sd300,
                      20'sd400, 20'sd400, 20'sd400, 20'sd400, 20'sd400, 20'sd400,
                      20'sd400, 20'sd400, -20'sd400, 20'sd1000, -20'sd2, 20'sd3};
      req_ch.valid = 1'b0;
      req_ch.sample = '0;
      for (int i = 0; i < DEPTH; i++) win[i] = 0;
      wr_pos = 0;
      seen = 0;
      prev_change = 0;
      switch_cnt = 0;
      period_reg = int'(wts_pkg::PERIOD_RESET);

      // first response after reset is fully known: nothing valid yet
      plan[0] = '{sample: 20'sh7ffff, known: 1'b1, stats: '0};
      foreach (dir_samples[i]) plan[i + 1] = '{sample: dir_samples[i], known: 1'b0, stats: '0};

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      foreach (plan[i]) send_sample(plan[i].sample, plan[i].known, plan[i].stats);

      sent = 0;
      foreach (periods[p]) begin
         write_period(periods[p]);
         for (int i = 0; i < counts[p]; i++) begin
            if (sent < 170) begin
               req_idle_pct = 27;
               rsp_idle_pct = 48;
            end else if (sent < 340) begin
               req_idle_pct = 48;
               rsp_idle_pct = 27;
            end else begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
            send_sample(random_sample(), 1'b0, '0);
            sent++;
         end
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait (pending_stats.size() == 0);
      repeat (DRAIN) @(negedge clock);
      if (errors == 0) $display("windowed_trend_statistics regression: pass");
      else $display("windowed_trend_statistics regression: fail");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/wts_pkg.sv
rtl/core/wts_req_if.sv
rtl/core/wts_rsp_if.sv
rtl/core/wts_ram.sv
rtl/core/wts_div.sv
rtl/core/wts_sqrt.sv
rtl/core/windowed_trend_statistics.sv
bench/windowed_trend_statistics_test.sv
